/* rtl/core/adc_to_timer_period_interp_macros.svh */
// ----------------------------------------------------------------------------
// adc_to_timer_period_interp assertion macros
// shorthand for the clocked, reset-qualified checks of the mapper
// ----------------------------------------------------------------------------
`ifndef ADC_TO_TIMER_PERIOD_INTERP_MACROS_SVH
`define ADC_TO_TIMER_PERIOD_INTERP_MACROS_SVH

// same-cycle implication
`define ATPI_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATPI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/atpi_pkg.sv */
// ----------------------------------------------------------------------------
// atpi_pkg
// widths, breakpoint tables and reciprocal constants of the period mapper
// ----------------------------------------------------------------------------
package atpi_pkg;

  localparam int unsigned BREAKPOINTS_DEF = 11;
  localparam int unsigned TABLE_CAP       = 16;

  localparam int unsigned ADC_W    = 12;
  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned PRESC_W  = 8;
  localparam int unsigned SEG_W    = $clog2(TABLE_CAP);

  localparam int unsigned DX_W    = 9;   // distance to upper breakpoint, <= 410
  localparam int unsigned DP_W    = 10;  // period span of a segment, <= 847
  localparam int unsigned NUM_W   = DX_W + DP_W;
  localparam int unsigned RECIP_W = 20;
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;
  localparam int unsigned Q_W     = 10;

  // floor(n / d) == (n * ceil(2^SHIFT / d)) >> SHIFT for all n < 2^NUM_W
  localparam int unsigned RECIP_SHIFT = NUM_W + 9;

  localparam logic [ADC_W-1:0]    LOW_EDGE   = ADC_W'(408);
  localparam logic [DP_W-1:0]     LOW_DP     = DP_W'(249);
  localparam logic [PERIOD_W-1:0] LOW_PERIOD = PERIOD_W'(1694);

  localparam logic [ADC_W-1:0] BP_X [TABLE_CAP] = '{
    12'd0,    12'd408,  12'd817,  12'd1227, 12'd1637, 12'd2046, 12'd2456, 12'd2866,
    12'd3275, 12'd3685, 12'd4095, 12'd0,    12'd0,    12'd0,    12'd0,    12'd0
  };

  localparam logic [PERIOD_W-1:0] BP_P [TABLE_CAP] = '{
    11'd0,   11'd1694, 11'd847, 11'd564, 11'd423, 11'd338, 11'd282, 11'd242,
    11'd211, 11'd188,  11'd169, 11'd0,   11'd0,   11'd0,   11'd0,   11'd0
  };

  // ceil(2^28 / segment width); segment 1 uses the low edge of 408
  localparam logic [RECIP_W-1:0] RECIP [TABLE_CAP] = '{
    20'd0,      20'd657931, 20'd656322, 20'd654721, 20'd654721, 20'd656322,
    20'd654721, 20'd654721, 20'd656322, 20'd654721, 20'd654721, 20'd0,
    20'd0,      20'd0,      20'd0,      20'd0
  };

  typedef struct packed {
    logic [SEG_W-1:0] seg;  // k with x[k-1] <= adc < x[k], 1 in the low band, last segment at the top
    logic             lo;   // reading at or below the low edge
    logic             hi;   // reading at or above the last breakpoint
  } atpi_seg_t;

endpackage

/* rtl/core/atpi_seg_find.sv */
// ----------------------------------------------------------------------------
// atpi_seg_find
// classifies a reading into the low band, an interior segment or the top
// ----------------------------------------------------------------------------
module atpi_seg_find import atpi_pkg::*; #(
  parameter int unsigned BREAKPOINTS = BREAKPOINTS_DEF
) (
  input  logic [ADC_W-1:0] adc_value_i,
  output atpi_seg_t        seg_o
);

  localparam int unsigned TOP = BREAKPOINTS - 1;

  always_comb begin
    seg_o.seg = SEG_W'(1);
    for (int i = 1; i < TABLE_CAP; i++) begin
      if (i < TOP && adc_value_i >= BP_X[i]) begin
        seg_o.seg = SEG_W'(i + 1);
      end
    end
    seg_o.lo = (adc_value_i <= LOW_EDGE);
    seg_o.hi = !seg_o.lo && !(adc_value_i < BP_X[SEG_W'(TOP)]);
    if (seg_o.lo) begin
      seg_o.seg = SEG_W'(1);
    end
  end

endmodule

/* rtl/core/adc_to_timer_period_interp.sv */
// ----------------------------------------------------------------------------
// adc_to_timer_period_interp
// piecewise linear map from a 12-bit converter reading to timer period and
// prescaler over a fixed breakpoint table, four register stages
// ----------------------------------------------------------------------------
// a request is taken into stage 1 and passes stages 2, 3 and 4 in order to valid_o
// throughput: one request per cycle, busy stays low, no stalls anywhere
// the multiply and the reciprocal multiply each own a stage, which sets depth
// reset clears only the valid bits of the stages; data registers are not reset
// the receiver cannot stall: each result is on the ports for one cycle only
module adc_to_timer_period_interp import atpi_pkg::*; #(
  parameter int unsigned BREAKPOINTS = BREAKPOINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ADC_W-1:0]    adc_value_i,
  output logic                valid_o,
  output logic [PERIOD_W-1:0] period_o,
  output logic [PRESC_W-1:0]  prescaler_o
);

`include "adc_to_timer_period_interp_macros.svh"

  localparam int unsigned TOP = BREAKPOINTS - 1;

  // the pipeline never holds off a request
  assign busy = 1'b0;

  // ---------------- stage 1: segment search ----------------
  atpi_seg_t seg_d, seg_q;
  logic [ADC_W-1:0] adc_q;
  logic v1_q;

  atpi_seg_find #(
    .BREAKPOINTS(BREAKPOINTS)
  ) u_seg_find (
    .adc_value_i(adc_value_i),
    .seg_o      (seg_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    adc_q <= adc_value_i;
    seg_q <= seg_d;
  end

  // ---------------- stage 2: distance times span ----------------
  logic [ADC_W-1:0]    dx_full;
  logic [DX_W-1:0]     dx;
  logic [PERIOD_W-1:0] p_lo, p_hi;
  logic [DP_W-1:0]     dp;
  logic [PERIOD_W-1:0] base_d;
  logic [NUM_W-1:0]    num_d, num_q;
  logic [RECIP_W-1:0]  recip_q;
  logic [PERIOD_W-1:0] base2_q;
  logic                lo2_q;
  logic                v2_q;

  always_comb begin
    p_lo    = BP_P[SEG_W'(seg_q.seg - 1'b1)];
    p_hi    = BP_P[seg_q.seg];
    // distance from the reading up to the segment's upper breakpoint
    dx_full = BP_X[seg_q.seg] - adc_q;
    dx      = seg_q.hi ? '0 : dx_full[DX_W-1:0];
    // low band scales the prescaler range, interior segments the period span
    if (seg_q.lo) begin
      dp = LOW_DP;
    end else if (seg_q.hi || p_lo < p_hi) begin
      dp = '0;
    end else begin
      dp = DP_W'(p_lo - p_hi);
    end
    // top band snaps to the last table period
    base_d = seg_q.hi ? BP_P[SEG_W'(TOP)] : p_hi;
    if (seg_q.lo) begin
      base_d = LOW_PERIOD;
    end
    num_d = NUM_W'(dx) * NUM_W'(dp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    recip_q <= RECIP[seg_q.seg];
    base2_q <= base_d;
    lo2_q   <= seg_q.lo;
  end

  // ---------------- stage 3: divide by segment width ----------------
  // exact floor division through a constant reciprocal per segment
  logic [PROD_W-1:0]   prod;
  logic [Q_W-1:0]      q_q;
  logic [PERIOD_W-1:0] base3_q;
  logic                lo3_q;
  logic                v3_q;

  assign prod = PROD_W'(num_q) * PROD_W'(recip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q     <= prod[RECIP_SHIFT +: Q_W];
    base3_q <= base2_q;
    lo3_q   <= lo2_q;
  end

  // ---------------- stage 4: result assembly ----------------
  logic [PERIOD_W-1:0] period_d, period_q;
  logic [PRESC_W-1:0]  presc_d, presc_q;
  logic                valid_q;

  always_comb begin
    if (lo3_q) begin
      // low band: fixed period, quotient is the prescaler
      period_d = base3_q;
      presc_d  = q_q[PRESC_W-1:0];
    end else begin
      period_d = base3_q + PERIOD_W'(q_q);
      presc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    presc_q  <= presc_d;
  end

  assign valid_o     = valid_q;
  assign period_o    = period_q;
  assign prescaler_o = presc_q;

  // ---------------- checks ----------------
  `ATPI_ASSERT_IMPL(a_fixed_latency, clk_i, rst_ni, 1'b1, valid_o == ($past(start, 4) && $past(rst_ni, 4) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1)), "result strobe does not follow request by four cycles")
  `ATPI_ASSERT_NEXT(a_last_stage, clk_i, rst_ni, v3_q, valid_o, "divide stage result not delivered")
  `ATPI_ASSERT_IMPL(a_presc_low_only, clk_i, rst_ni, valid_o && (prescaler_o != '0), period_o == LOW_PERIOD, "nonzero prescaler outside the low band")
  `ATPI_ASSERT_IMPL(a_period_max, clk_i, rst_ni, valid_o, period_o <= LOW_PERIOD, "period above the table maximum")

endmodule
